FILE: hdl/sct_pkg.sv
// Shared widths, angle constants and item types of the Taylor sine/cosine pipeline.
package sct_pkg;

  // Widths of the reduction word, the Q32 angle, a series term, the running sum and
  // the rounded product that is divided by the term index.
  localparam int DW = 62;
  localparam int XW = 34;
  localparam int TW = 35;
  localparam int SW = 37;
  localparam int VW = 37;

  // Angle constants in Q52.
  localparam logic signed [DW-1:0] HALF_PI_Q52 = 62'sh0019_21FB_5444_2D18;
  localparam logic signed [DW-1:0] PI_Q52      = 62'sh0032_43F6_A888_5A31;
  localparam logic signed [DW-1:0] TWO_PI_Q52  = 62'sh0064_87ED_5110_B461;

  // 2^76 / TWO_PI_Q52, so that (d >>> 44) * TWO_PI_RECIP >>> 32 estimates d / (2*pi).
  localparam logic [21:0] TWO_PI_RECIP = 22'd2670177;

  localparam int TERM_FIRST = 2;
  localparam int TERM_LAST  = 11;

  // ceil(2^21 / n) and ceil(2^28 / n): exact reciprocals for 17-bit and 24-bit dividends.
  localparam logic [20:0] RECIP_HI [TERM_FIRST:TERM_LAST] = '{
    21'((2**21 + 1) / 2), 21'((2**21 + 2) / 3), 21'((2**21 + 3) / 4),
    21'((2**21 + 4) / 5), 21'((2**21 + 5) / 6), 21'((2**21 + 6) / 7),
    21'((2**21 + 7) / 8), 21'((2**21 + 8) / 9), 21'((2**21 + 9) / 10),
    21'((2**21 + 10) / 11)
  };
  localparam logic [27:0] RECIP_LO [TERM_FIRST:TERM_LAST] = '{
    28'((2**28 + 1) / 2), 28'((2**28 + 2) / 3), 28'((2**28 + 3) / 4),
    28'((2**28 + 4) / 5), 28'((2**28 + 5) / 6), 28'((2**28 + 6) / 7),
    28'((2**28 + 7) / 8), 28'((2**28 + 8) / 9), 28'((2**28 + 9) / 10),
    28'((2**28 + 10) / 11)
  };

  localparam logic signed [SW-1:0] VALUE_MAX = SW'(32'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] VALUE_MIN = SW'(32'sh8000_0000);

  // Fixed settings of one term stage.
  typedef struct packed {
    logic [3:0]  n;
    logic [2:0]  half;
    logic [20:0] recip_hi;
    logic [27:0] recip_lo;
    logic        acc;
    logic        acc_sub;
  } sct_term_cfg_t;

  // Data that travels from one term stage to the next.
  typedef struct packed {
    logic [XW-1:0]        x;
    logic [TW-1:0]        t;
    logic signed [SW-1:0] sum;
    logic                 neg;
  } sct_item_t;

endpackage

FILE: hdl/sct_term.sv
// One Taylor term stage: t_n = round(round(t_(n-1) * x) / n), with the sum update.
module sct_term (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  sct_pkg::sct_term_cfg_t cfg,
  input  logic                   in_valid,
  input  sct_pkg::sct_item_t     in_item,
  output logic                   out_valid,
  output sct_pkg::sct_item_t     out_item
);

  logic [2:0] stage_valid;

  // Stage 1: partial products and the sum update.
  logic [52:0]                         prod_hi_next;
  logic [50:0]                         prod_lo_next;
  logic signed [sct_pkg::SW-1:0]       sum_next;
  logic signed [sct_pkg::SW-1:0]       term_ext;
  logic [52:0]                         s1_prod_hi;
  logic [50:0]                         s1_prod_lo;
  logic [sct_pkg::XW-1:0]              s1_x;
  logic signed [sct_pkg::SW-1:0]       s1_sum;
  logic                                s1_neg;

  // Stage 2: rounded product plus n/2.
  logic [53:0]                         acc_next;
  logic [sct_pkg::VW-1:0]              s2_v;
  logic [sct_pkg::XW-1:0]              s2_x;
  logic signed [sct_pkg::SW-1:0]       s2_sum;
  logic                                s2_neg;

  // Stage 3: quotient and remainder of the upper part.
  logic [16:0]                         v_hi;
  logic [37:0]                         recip_prod_hi;
  logic [16:0]                         qh_next;
  logic [16:0]                         qh_times_n;
  logic [16:0]                         rh_full;
  logic [16:0]                         s3_qh;
  logic [3:0]                          s3_rh;
  logic [19:0]                         s3_vl;
  logic [sct_pkg::XW-1:0]              s3_x;
  logic signed [sct_pkg::SW-1:0]       s3_sum;
  logic                                s3_neg;

  // Stage 4: quotient of the remainder joined with the lower part.
  logic [23:0]                         w;
  logic [51:0]                         recip_prod_lo;
  logic [19:0]                         ql;

  assign prod_hi_next = 53'(in_item.t) * 53'(in_item.x[sct_pkg::XW-1:16]);
  assign prod_lo_next = 51'(in_item.t) * 51'(in_item.x[15:0]);
  assign term_ext     = $signed(sct_pkg::SW'(in_item.t));

  // Even stages fold in the odd term that arrives with the item.
  always_comb begin
    sum_next = in_item.sum;
    if (cfg.acc) begin
      if (cfg.acc_sub) begin
        sum_next = in_item.sum - term_ext;
      end else begin
        sum_next = in_item.sum + term_ext;
      end
    end
  end

  // Adding n/2 after the shift by 16 is the same as adding it shifted up before.
  assign acc_next = 54'(s1_prod_hi) + 54'(s1_prod_lo[50:16]) + 54'(2**15)
                  + {35'b0, cfg.half, 16'b0};

  // The dividend is split so that both reciprocal products stay narrow and exact.
  assign v_hi          = s2_v[36:20];
  assign recip_prod_hi = 38'(v_hi) * 38'(cfg.recip_hi);
  assign qh_next       = recip_prod_hi[37:21];
  assign qh_times_n    = qh_next * 17'(cfg.n);
  assign rh_full       = v_hi - qh_times_n;

  assign w             = {s3_rh, s3_vl};
  assign recip_prod_lo = 52'(w) * 52'(cfg.recip_lo);
  assign ql            = recip_prod_lo[47:28];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      out_valid   <= 1'b0;
    end else if (adv) begin
      stage_valid <= {stage_valid[1:0], in_valid};
      out_valid   <= stage_valid[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_hi   <= prod_hi_next;
      s1_prod_lo   <= prod_lo_next;
      s1_x         <= in_item.x;
      s1_sum       <= sum_next;
      s1_neg       <= in_item.neg;

      s2_v         <= acc_next[52:16];
      s2_x         <= s1_x;
      s2_sum       <= s1_sum;
      s2_neg       <= s1_neg;

      s3_qh        <= qh_next;
      s3_rh        <= rh_full[3:0];
      s3_vl        <= s2_v[19:0];
      s3_x         <= s2_x;
      s3_sum       <= s2_sum;
      s3_neg       <= s2_neg;

      out_item.x   <= s3_x;
      out_item.t   <= {s3_qh[14:0], ql};
      out_item.sum <= s3_sum;
      out_item.neg <= s3_neg;
    end
  end

endmodule

FILE: hdl/sine_cosine_taylor_unit.sv
// Top level of the pipelined six-term Taylor sine/cosine unit.
// Throughput: one angle per cycle unless the output stalls; six reduction stages, ten
// four-stage term stages (two multipliers and two reciprocal products each) and two
// rounding stages.
// The whole pipeline holds while a result waits on res_ready.
// Reset clears the valid bits only; the data registers are not reset.
module sine_cosine_taylor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic signed [31:0] angle,
  output logic        res_valid,
  input  logic        res_ready,
  output logic signed [31:0] value
);

  logic adv;

  // Reduction stages.
  logic signed [sct_pkg::DW-1:0] d_sin;
  logic signed [sct_pkg::DW-1:0] d_next;
  logic                          r1_valid;
  logic signed [sct_pkg::DW-1:0] r1_d;

  logic signed [17:0]            d_hi;
  logic signed [40:0]            k_prod;
  logic                          big_next;
  logic                          r2_valid;
  logic                          r2_big;
  logic                          r2_lt0;
  logic signed [sct_pkg::DW-1:0] r2_e;
  logic signed [7:0]             r2_k;

  logic signed [sct_pkg::DW-1:0] k_span;
  logic signed [sct_pkg::DW-1:0] r0_full;
  logic                          r3_valid;
  logic                          r3_big;
  logic                          r3_lt0;
  logic signed [57:0]            r3_r0;
  logic [54:0]                   r3_e_low;

  logic signed [57:0]            r_mid;
  logic signed [57:0]            r_add;
  logic signed [57:0]            r_sub;
  logic signed [57:0]            r_sel;
  logic [54:0]                   red_next;
  logic                          r4_valid;
  logic [54:0]                   r4_red;

  logic                          half_next;
  logic [53:0]                   red2_next;
  logic                          r5_valid;
  logic                          r5_neg;
  logic [53:0]                   r5_red;

  logic [54:0]                   x_round;
  logic                          r6_valid;
  logic                          r6_neg;
  logic [sct_pkg::XW-1:0]        r6_x;

  // Term chain: index g holds the output of the stage for term n = g.
  logic               term_valid [sct_pkg::TERM_FIRST-1:sct_pkg::TERM_LAST];
  sct_pkg::sct_item_t term_item  [sct_pkg::TERM_FIRST-1:sct_pkg::TERM_LAST];

  // Final stages.
  logic signed [sct_pkg::SW-1:0] f_sum_next;
  logic                          f_valid;
  logic                          f_neg;
  logic signed [sct_pkg::SW-1:0] f_sum;
  logic signed [sct_pkg::SW-1:0] q_shift;
  logic signed [sct_pkg::SW-1:0] q_signed;
  logic signed [31:0]            value_next;

  assign adv       = !res_valid || res_ready;
  assign req_ready = adv;

  // Angle to Q52; a cosine request becomes the sine of pi/2 minus the angle.
  assign d_sin  = {{2{angle[31]}}, angle, 28'b0};
  assign d_next = req_type ? sct_pkg::HALF_PI_Q52 - d_sin : d_sin;

  // Estimate of the number of whole turns; it is off by at most one either way.
  assign d_hi     = r1_d[sct_pkg::DW-1:44];
  assign k_prod   = d_hi * $signed({1'b0, sct_pkg::TWO_PI_RECIP});
  assign big_next = r1_d > sct_pkg::TWO_PI_Q52;

  assign k_span  = r2_k * sct_pkg::TWO_PI_Q52;
  assign r0_full = r2_e - k_span;

  // Above 2*pi the value is reduced as (d - 1) mod 2*pi + 1, so 2*pi itself stays.
  assign r_mid = r3_r0 + $signed({57'b0, r3_big});
  assign r_add = r_mid + 58'(sct_pkg::TWO_PI_Q52);
  assign r_sub = r_mid - 58'(sct_pkg::TWO_PI_Q52);

  always_comb begin
    if (r3_r0[57]) begin
      r_sel = r_add;
    end else if (r3_r0 >= 58'(sct_pkg::TWO_PI_Q52)) begin
      r_sel = r_sub;
    end else begin
      r_sel = r_mid;
    end
    if (r3_big || r3_lt0) begin
      red_next = r_sel[54:0];
    end else begin
      red_next = r3_e_low;
    end
  end

  assign half_next = r4_red > 55'(sct_pkg::PI_Q52);
  assign red2_next = half_next ? 54'(r4_red - 55'(sct_pkg::PI_Q52)) : r4_red[53:0];

  assign x_round = 55'(r5_red) + 55'(2**19);

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
      r4_valid <= 1'b0;
      r5_valid <= 1'b0;
      r6_valid <= 1'b0;
    end else if (adv) begin
      r1_valid <= req_valid;
      r2_valid <= r1_valid;
      r3_valid <= r2_valid;
      r4_valid <= r3_valid;
      r5_valid <= r4_valid;
      r6_valid <= r5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_d     <= d_next;

      r2_big   <= big_next;
      r2_lt0   <= r1_d[sct_pkg::DW-1];
      r2_e     <= r1_d - sct_pkg::DW'(big_next);
      r2_k     <= k_prod[39:32];

      r3_big   <= r2_big;
      r3_lt0   <= r2_lt0;
      r3_r0    <= r0_full[57:0];
      r3_e_low <= r2_e[54:0];

      r4_red   <= red_next;

      r5_neg   <= half_next;
      r5_red   <= red2_next;

      r6_neg   <= r5_neg;
      r6_x     <= x_round[53:20];
    end
  end

  // The first term is x itself; the sum starts at zero and takes it in the next stage.
  always_comb begin
    term_valid[sct_pkg::TERM_FIRST-1]     = r6_valid;
    term_item[sct_pkg::TERM_FIRST-1].x    = r6_x;
    term_item[sct_pkg::TERM_FIRST-1].t    = sct_pkg::TW'(r6_x);
    term_item[sct_pkg::TERM_FIRST-1].sum  = '0;
    term_item[sct_pkg::TERM_FIRST-1].neg  = r6_neg;
  end

  for (genvar g = sct_pkg::TERM_FIRST; g <= sct_pkg::TERM_LAST; g++) begin : g_term
    localparam sct_pkg::sct_term_cfg_t TermCfg = '{
      n:        4'(g),
      half:     3'(g / 2),
      recip_hi: sct_pkg::RECIP_HI[g],
      recip_lo: sct_pkg::RECIP_LO[g],
      acc:      (g % 2 == 0),
      acc_sub:  (g % 4 == 0)
    };

    sct_term u_term (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cfg       (TermCfg),
      .in_valid  (term_valid[g-1]),
      .in_item   (term_item[g-1]),
      .out_valid (term_valid[g]),
      .out_item  (term_item[g])
    );
  end

  // The last term is negative; the +2 is the half-up rounding offset for Q2.30.
  assign f_sum_next = term_item[sct_pkg::TERM_LAST].sum
                    - $signed(sct_pkg::SW'(term_item[sct_pkg::TERM_LAST].t))
                    + sct_pkg::SW'(2);

  assign q_shift  = f_sum >>> 2;
  assign q_signed = f_neg ? -q_shift : q_shift;

  always_comb begin
    if (q_signed > sct_pkg::VALUE_MAX) begin
      value_next = 32'(sct_pkg::VALUE_MAX);
    end else if (q_signed < sct_pkg::VALUE_MIN) begin
      value_next = 32'(sct_pkg::VALUE_MIN);
    end else begin
      value_next = q_signed[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      f_valid   <= term_valid[sct_pkg::TERM_LAST];
      res_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_sum <= f_sum_next;
      f_neg <= term_item[sct_pkg::TERM_LAST].neg;
      value <= value_next;
    end
  end

  // The turn reduction always lands in 0..2*pi, and the half-turn fold in 0..pi.
  a_turn_range : assert property (@(posedge clk) disable iff (rst)
    r4_valid |-> r4_red <= 55'(sct_pkg::TWO_PI_Q52))
    else $error("reduced angle above two pi");

  a_half_range : assert property (@(posedge clk) disable iff (rst)
    r5_valid |-> r5_red <= 54'(sct_pkg::PI_Q52))
    else $error("folded angle above pi");

  // On 0..pi the six-term sum stays well inside +-1.25.
  a_value_range : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (value < 32'sh5000_0000) && (value > -32'sh5000_0000))
    else $error("series result out of range");

endmodule
